>>> hw/rtl/rational_number_sorter_defines.svh
// Assertion macros for the rational number sorter RTL.
// Assertions are compiled only when SYNTHESIS is not defined.
// Uses the enclosing module's clk and rst.
`ifndef RATIONAL_NUMBER_SORTER_DEFINES_SVH
`define RATIONAL_NUMBER_SORTER_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define RNS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rational_number_sorter: assertion failed");

// Expression must never be true outside reset.
`define RNS_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("rational_number_sorter: forbidden condition");

`else

`define RNS_ASSERT(lbl, prop)
`define RNS_NEVER(lbl, expr)

`endif

`endif

>>> hw/rtl/rns_pkg.sv
// Shared constants, types and FSM states of the rational number sorter.
// No dependencies.
`timescale 1ns / 1ps

package rns_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int ENTRY_W   = 2 * DATA_W;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    S_COLLECT,
    S_EMPTY,
    S_READ,
    S_MUL,
    S_CMP,
    S_EMIT
  } state_t;

  // Outcome of comparing fraction a against fraction b
  typedef struct packed {
    logic a_gt_b;
    logic a_lt_b;
  } cmp_res_t;

endpackage

>>> hw/rtl/rns_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module rns_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/rns_cmp.sv
// Exact fraction comparator: registered cross products, then compare.
// Depends on rns_pkg.
`timescale 1ns / 1ps

module rns_cmp
  import rns_pkg::*;
(
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [DATA_W-1:0] a_num,
  input  logic signed [DATA_W-1:0] a_den,
  input  logic signed [DATA_W-1:0] b_num,
  input  logic signed [DATA_W-1:0] b_den,
  output cmp_res_t                 res
);

  logic signed [2*DATA_W-1:0] prod_a;
  logic signed [2*DATA_W-1:0] prod_b;
  logic                       flip;

  // a/b order follows a_num*b_den vs b_num*a_den, reversed when
  // exactly one denominator is negative
  always_ff @(posedge clk) begin
    if (load) begin
      prod_a <= (2*DATA_W)'(a_num) * (2*DATA_W)'(b_den);
      prod_b <= (2*DATA_W)'(b_num) * (2*DATA_W)'(a_den);
      flip   <= a_den[DATA_W-1] ^ b_den[DATA_W-1];
    end
  end

  always_comb begin
    res.a_gt_b = flip ? (prod_a < prod_b) : (prod_a > prod_b);
    res.a_lt_b = flip ? (prod_a > prod_b) : (prod_a < prod_b);
  end

endmodule

>>> hw/rtl/rational_number_sorter.sv
// Rational number sorter top level: collect FSM, selection-sort sequencer.
// Depends on rns_pkg, rns_ram, rns_cmp and rational_number_sorter_defines.svh.
`timescale 1ns / 1ps
//
// Usage:
//  - Input: a fraction (num_in, den_in, last_in) transfers on a rising edge
//    with start high and busy low. While collecting, one transfer per cycle.
//    A zero denominator or a transfer beyond MAX_ITEMS is dropped.
//  - The transfer carrying last_in closes the run; busy then rises until
//    the whole sorted run has been emitted. The next transfer can be taken
//    in the cycle after the final result.
//  - Output: each result is shown for exactly one cycle with result_valid
//    high. There is no back pressure; the receiver must take every strobe.
//    last_out marks the final result, dropped_flag (on that result only)
//    reports a drop during the run. An all-dropped run yields one marker
//    result 0/0 with last_out high, in the cycle after the closing transfer.
//  - Config: cfg_data (sort_descending) is written when cfg_valid and
//    cfg_ready are high; cfg_ready is always high. Write only while idle.
//  - Sorting: each pass scans the whole store once: a remaining entry takes
//    a RAM read, a multiply and a compare, an emitted entry a RAM read and
//    a mark check, and the pass ends with one emit of the best entry. The
//    pace is set by the single shared comparator and the one-read-port store.
//  - Reset (rst, synchronous): empty store, no drops, descending order.
//
module rational_number_sorter
  import rns_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // input channel
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] num_in,
  input  logic signed [DATA_W-1:0] den_in,
  input  logic                     last_in,
  // config channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_data,
  // result channel
  output logic                     result_valid,
  output logic signed [DATA_W-1:0] num_out,
  output logic signed [DATA_W-1:0] den_out,
  output logic                     last_out,
  output logic                     dropped_flag
);

`include "rational_number_sorter_defines.svh"

  state_t state, state_next;

  logic                     sort_descending;
  logic [CNT_W-1:0]         count;
  logic                     drop_seen;
  logic [IDX_W-1:0]         scan_idx;
  logic [IDX_W-1:0]         out_pos;
  logic                     found;
  logic signed [DATA_W-1:0] best_num;
  logic signed [DATA_W-1:0] best_den;
  logic [IDX_W-1:0]         best_idx;

  logic                     in_xfer;
  logic                     store_ok;
  logic                     scan_last;
  logic                     skip;
  logic                     take;
  logic [ENTRY_W-1:0]       rd_data;
  logic                     done_rd;
  logic signed [DATA_W-1:0] rd_num;
  logic signed [DATA_W-1:0] rd_den;
  cmp_res_t                 cmp_res;

  assign busy      = (state != S_COLLECT);
  assign cfg_ready = 1'b1;
  assign in_xfer   = start && !busy;
  assign store_ok  = (den_in != '0) && (count != CNT_W'(MAX_ITEMS));

  assign rd_num = rd_data[ENTRY_W-1:DATA_W];
  assign rd_den = rd_data[DATA_W-1:0];

  assign scan_last = (CNT_W'(scan_idx) + CNT_W'(1)) == count;
  // sent mark of the entry read in the previous cycle
  assign skip      = done_rd;

  // Strict "goes before" keeps the lowest index among equal values: stable
  assign take = !found ||
                (sort_descending ? cmp_res.a_gt_b : cmp_res.a_lt_b);

  // Store: written only while collecting, read only while sorting, so the
  // two ports never touch the same entry in overlapping cycles.
  rns_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_xfer && store_ok),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data ({num_in, den_in}),
    .rd_en   (state == S_READ),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  // Sent marks: cleared as each entry is stored, set as it is emitted.
  // Written only in S_COLLECT and S_EMIT, read only in S_READ.
  rns_ram #(
    .WIDTH(1),
    .DEPTH(MAX_ITEMS)
  ) u_done (
    .clk     (clk),
    .wr_en   ((in_xfer && store_ok) || (state == S_EMIT)),
    .wr_addr ((state == S_EMIT) ? best_idx : count[IDX_W-1:0]),
    .wr_data (state == S_EMIT),
    .rd_en   (state == S_READ),
    .rd_addr (scan_idx),
    .rd_data (done_rd)
  );

  // candidate (a) against current best (b)
  rns_cmp u_cmp (
    .clk   (clk),
    .load  (state == S_MUL),
    .a_num (rd_num),
    .a_den (rd_den),
    .b_num (best_num),
    .b_den (best_den),
    .res   (cmp_res)
  );

  // Results come straight from the best-entry registers
  assign result_valid = (state == S_EMIT) || (state == S_EMPTY);
  assign num_out      = best_num;
  assign den_out      = best_den;
  assign last_out     = (state == S_EMPTY) ||
                        ((CNT_W'(out_pos) + CNT_W'(1)) == count);
  assign dropped_flag = last_out && drop_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_COLLECT: begin
        if (in_xfer && last_in) begin
          if (store_ok || (count != '0)) begin
            state_next = S_READ;
          end else begin
            state_next = S_EMPTY;
          end
        end
      end
      S_EMPTY: state_next = S_COLLECT;
      S_READ: state_next = S_MUL;
      S_MUL: begin
        if (!skip) begin
          state_next = S_CMP;
        end else if (scan_last) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_READ;
        end
      end
      S_CMP: state_next = scan_last ? S_EMIT : S_READ;
      S_EMIT: state_next = last_out ? S_COLLECT : S_READ;
      default: state_next = S_COLLECT;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_descending <= 1'b1;
      count           <= '0;
      drop_seen       <= 1'b0;
      scan_idx        <= '0;
      out_pos         <= '0;
      found           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sort_descending <= cfg_data;
      end
      unique case (state)
        S_COLLECT: begin
          if (in_xfer) begin
            if (store_ok) begin
              count <= count + CNT_W'(1);
            end else begin
              drop_seen <= 1'b1;
            end
          end
          scan_idx <= '0;
          out_pos  <= '0;
          found    <= 1'b0;
        end
        S_EMPTY: begin
          drop_seen <= 1'b0;
        end
        S_READ: begin
        end
        S_MUL: begin
          if (skip && !scan_last) begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_CMP: begin
          if (take) begin
            found <= 1'b1;
          end
          if (!scan_last) begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_EMIT: begin
          scan_idx <= '0;
          found    <= 1'b0;
          if (last_out) begin
            count     <= '0;
            drop_seen <= 1'b0;
            out_pos   <= '0;
          end else begin
            out_pos <= out_pos + IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Best-entry payload registers
  always_ff @(posedge clk) begin
    if ((state == S_COLLECT) && in_xfer && last_in) begin
      // zero marker in case the run turns out empty
      best_num <= '0;
      best_den <= '0;
    end else if ((state == S_CMP) && take) begin
      best_num <= rd_num;
      best_den <= rd_den;
      best_idx <= scan_idx;
    end
  end

  `RNS_NEVER(a_count_range, count > CNT_W'(MAX_ITEMS))
  `RNS_ASSERT(a_emit_has_best, (state == S_EMIT) |-> found)
  `RNS_ASSERT(a_close_goes_busy, (in_xfer && last_in) |=> busy)
  `RNS_ASSERT(a_run_cleared, (result_valid && last_out) |=> (count == '0 && !drop_seen))
  `RNS_ASSERT(a_no_result_idle, result_valid |-> busy)

endmodule
